FILE: src/rti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rti_pkg;

	localparam int COORD_BITS_DEF = 20;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 32;
	localparam int DIST_BITS      = 32;
	// t is Q16.16, so the numerator is shifted by this much
	localparam int T_SHIFT        = 16;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ORIGIN_X = 8'd0,
		REG_ORIGIN_Y = 8'd1,
		REG_ORIGIN_Z = 8'd2,
		REG_DIR_X    = 8'd3,
		REG_DIR_Y    = 8'd4,
		REG_DIR_Z    = 8'd5,
		REG_DET_EPS  = 8'd6,
		REG_MIN_DIST = 8'd7
	} reg_index_t;

endpackage

`default_nettype wire

FILE: src/rti_div.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per pipeline stage
module rti_div import rti_pkg::*; #(
	parameter int DW = 66
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic                 in_cand,
	input  logic                 in_sat,
	input  logic [DW-1:0]        in_den,
	input  logic [DW-1:0]        in_num,
	output logic                 out_valid,
	output logic                 out_cand,
	output logic                 out_sat,
	output logic [DIST_BITS-1:0] out_quo
);

	localparam int NS = DIST_BITS;

	logic                 valid_s [NS+1];
	logic                 cand_s  [NS+1];
	logic                 sat_s   [NS+1];
	logic [DW-1:0]        den_s   [NS+1];
	logic [DW-1:0]        rem_s   [NS+1];
	logic [T_SHIFT-1:0]   low_s   [NS+1];
	logic [DIST_BITS-1:0] quo_s   [NS+1];

	assign valid_s[0] = in_valid;
	assign cand_s[0]  = in_cand;
	assign sat_s[0]   = in_sat;
	assign den_s[0]   = in_den;
	assign rem_s[0]   = in_num >> T_SHIFT;
	assign low_s[0]   = in_num[T_SHIFT-1:0];
	assign quo_s[0]   = '0;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam int BIT = NS - 1 - k;
		logic          nbit;
		logic [DW:0]   trial;
		logic          ge;

		if (BIT >= T_SHIFT) begin : g_num
			assign nbit = low_s[k][BIT-T_SHIFT];
		end else begin : g_zero
			assign nbit = 1'b0;
		end

		assign trial = {rem_s[k], nbit};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cand_s[k+1] <= cand_s[k];
				sat_s[k+1]  <= sat_s[k];
				den_s[k+1]  <= den_s[k];
				low_s[k+1]  <= low_s[k];
				rem_s[k+1]  <= ge ? DW'(trial - {1'b0, den_s[k]}) : DW'(trial);
				quo_s[k+1]  <= {quo_s[k][DIST_BITS-2:0], ge};
			end
		end
	end

	assign out_valid = valid_s[NS];
	assign out_cand  = cand_s[NS];
	assign out_sat   = sat_s[NS];
	assign out_quo   = quo_s[NS];

endmodule

`default_nettype wire

FILE: src/ray_triangle_intersection.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                 payload
// in        input      in_valid / in_stall       vertex0_x .. vertex2_z
// out       output     out_valid / out_stall     hit, hit_distance
// cfg       input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one triangle per cycle while not stalled; the stages are edges, cross products,
// dot products, sign fix and tests, 32 divider stages (one quotient bit each),
// then the output register.
// reset clears valid bits and loads the register defaults.
// out_stall freezes the whole pipeline while out_valid is high; in_stall follows it combinationally.
module ray_triangle_intersection import rti_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] vertex0_x,
	input  logic signed [COORD_BITS-1:0] vertex0_y,
	input  logic signed [COORD_BITS-1:0] vertex0_z,
	input  logic signed [COORD_BITS-1:0] vertex1_x,
	input  logic signed [COORD_BITS-1:0] vertex1_y,
	input  logic signed [COORD_BITS-1:0] vertex1_z,
	input  logic signed [COORD_BITS-1:0] vertex2_x,
	input  logic signed [COORD_BITS-1:0] vertex2_y,
	input  logic signed [COORD_BITS-1:0] vertex2_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic [DIST_BITS-1:0]         hit_distance
);

	localparam int C  = COORD_BITS;
	localparam int E  = C + 1;
	localparam int X  = 2 * E + 1;
	localparam int DW = 3 * E + 3;

	logic signed [C-1:0] org_x_q, org_y_q, org_z_q;
	logic signed [C-1:0] dir_x_q, dir_y_q, dir_z_q;
	logic [CFG_DATA_BITS-1:0] eps_q, min_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0;
			org_y_q <= '0;
			org_z_q <= '0;
			dir_x_q <= C'(1) << FRAC_BITS;
			dir_y_q <= '0;
			dir_z_q <= '0;
			eps_q   <= CFG_DATA_BITS'(1);
			min_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ORIGIN_X: org_x_q <= C'(cfg_data);
				REG_ORIGIN_Y: org_y_q <= C'(cfg_data);
				REG_ORIGIN_Z: org_z_q <= C'(cfg_data);
				REG_DIR_X:    dir_x_q <= C'(cfg_data);
				REG_DIR_Y:    dir_y_q <= C'(cfg_data);
				REG_DIR_Z:    dir_z_q <= C'(cfg_data);
				REG_DET_EPS:  eps_q   <= cfg_data;
				REG_MIN_DIST: min_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic out_valid_q;
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// stage 1: edges and origin offset
	logic valid_s1;
	logic signed [E-1:0] e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;
	logic signed [E-1:0] sx_s1, sy_s1, sz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1x_s1 <= E'(vertex1_x) - E'(vertex0_x);
			e1y_s1 <= E'(vertex1_y) - E'(vertex0_y);
			e1z_s1 <= E'(vertex1_z) - E'(vertex0_z);
			e2x_s1 <= E'(vertex2_x) - E'(vertex0_x);
			e2y_s1 <= E'(vertex2_y) - E'(vertex0_y);
			e2z_s1 <= E'(vertex2_z) - E'(vertex0_z);
			sx_s1  <= E'(org_x_q) - E'(vertex0_x);
			sy_s1  <= E'(org_y_q) - E'(vertex0_y);
			sz_s1  <= E'(org_z_q) - E'(vertex0_z);
		end
	end

	// stage 2: h = dir x e2, q = s x e1
	logic valid_s2;
	logic signed [X-1:0] hx_s2, hy_s2, hz_s2, qx_s2, qy_s2, qz_s2;
	logic signed [E-1:0] e1x_s2, e1y_s2, e1z_s2, e2x_s2, e2y_s2, e2z_s2;
	logic signed [E-1:0] sx_s2, sy_s2, sz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hx_s2 <= X'(dir_y_q) * X'(e2z_s1) - X'(dir_z_q) * X'(e2y_s1);
			hy_s2 <= X'(dir_z_q) * X'(e2x_s1) - X'(dir_x_q) * X'(e2z_s1);
			hz_s2 <= X'(dir_x_q) * X'(e2y_s1) - X'(dir_y_q) * X'(e2x_s1);
			qx_s2 <= X'(sy_s1) * X'(e1z_s1) - X'(sz_s1) * X'(e1y_s1);
			qy_s2 <= X'(sz_s1) * X'(e1x_s1) - X'(sx_s1) * X'(e1z_s1);
			qz_s2 <= X'(sx_s1) * X'(e1y_s1) - X'(sy_s1) * X'(e1x_s1);
			e1x_s2 <= e1x_s1;
			e1y_s2 <= e1y_s1;
			e1z_s2 <= e1z_s1;
			e2x_s2 <= e2x_s1;
			e2y_s2 <= e2y_s1;
			e2z_s2 <= e2z_s1;
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
			sz_s2  <= sz_s1;
		end
	end

	// stage 3: determinant and the three numerators
	logic valid_s3;
	logic signed [DW-1:0] a_s3, u_s3, v_s3, t_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= DW'(e1x_s2) * DW'(hx_s2) + DW'(e1y_s2) * DW'(hy_s2)
				+ DW'(e1z_s2) * DW'(hz_s2);
			u_s3 <= DW'(sx_s2) * DW'(hx_s2) + DW'(sy_s2) * DW'(hy_s2)
				+ DW'(sz_s2) * DW'(hz_s2);
			v_s3 <= DW'(dir_x_q) * DW'(qx_s2) + DW'(dir_y_q) * DW'(qy_s2)
				+ DW'(dir_z_q) * DW'(qz_s2);
			t_s3 <= DW'(e2x_s2) * DW'(qx_s2) + DW'(e2y_s2) * DW'(qy_s2)
				+ DW'(e2z_s2) * DW'(qz_s2);
		end
	end

	// stage 4: fold the sign of the determinant in, range tests
	logic neg;
	logic signed [DW:0] an, un, vn, tn;
	logic signed [DW+1:0] uv;
	logic cand_c, sat_c;

	always_comb begin
		neg = a_s3[DW-1];
		an  = neg ? -(DW+1)'(a_s3) : (DW+1)'(a_s3);
		un  = neg ? -(DW+1)'(u_s3) : (DW+1)'(u_s3);
		vn  = neg ? -(DW+1)'(v_s3) : (DW+1)'(v_s3);
		tn  = neg ? -(DW+1)'(t_s3) : (DW+1)'(t_s3);
		uv  = (DW+2)'(un) + (DW+2)'(vn);
		cand_c = (a_s3 != '0)
			&& (an >= $signed({1'b0, (DW)'(eps_q)}))
			&& !un[DW] && (un <= an)
			&& !vn[DW] && (uv <= (DW+2)'(an))
			&& !tn[DW] && (tn != '0);
		// quotient would not fit in 32 bits
		sat_c = {{(DIST_BITS - T_SHIFT){1'b0}}, tn[DW-1:0]}
			>= {an[DW-1:0], {(DIST_BITS - T_SHIFT){1'b0}}};
	end

	logic valid_s4, cand_s4, sat_s4;
	logic [DW-1:0] den_s4, num_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cand_s4 <= cand_c;
			sat_s4  <= sat_c;
			den_s4  <= an[DW-1:0];
			num_s4  <= cand_c && !sat_c ? tn[DW-1:0] : '0;
		end
	end

	logic                 dv_valid, dv_cand, dv_sat;
	logic [DIST_BITS-1:0] dv_quo;

	rti_div #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s4),
		.in_cand  (cand_s4),
		.in_sat   (sat_s4),
		.in_den   (den_s4),
		.in_num   (num_s4),
		.out_valid(dv_valid),
		.out_cand (dv_cand),
		.out_sat  (dv_sat),
		.out_quo  (dv_quo)
	);

	logic [DIST_BITS-1:0] t_dist;
	logic                 hit_c;
	assign t_dist = dv_sat ? '1 : dv_quo;
	assign hit_c  = dv_cand && (t_dist > min_q);

	logic                 hit_q;
	logic [DIST_BITS-1:0] dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= hit_c;
			dist_q <= hit_c ? t_dist : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign hit_distance = dist_q;

endmodule

`default_nettype wire
